[rtl/core/msp_flow_frame_parser_macros.svh]
// Assertion macros for the MSP flow frame parser.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MSP_FLOW_FRAME_PARSER_MACROS_SVH
`define MSP_FLOW_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mspffp_pkg.sv]
// Shared constants and controller/datapath interface types for the
// MSP flow frame parser. No dependencies.
package mspffp_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 8;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OUT_W   = 56;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'h24;
  localparam logic [REG_W-1:0]  CMD_DISTANCE = 16'd7937;
  localparam logic [REG_W-1:0]  CMD_FLOW     = 16'd7938;

  // Frame positions
  localparam logic [POS_W-1:0] POS_CMD_LO    = 5'd4;
  localparam logic [POS_W-1:0] POS_CMD_HI    = 5'd5;
  localparam logic [POS_W-1:0] POS_PAY_FIRST = 5'd9;
  localparam logic [POS_W-1:0] POS_WORD0_END = 5'd12;
  localparam logic [POS_W-1:0] POS_PAY_LAST  = 5'd16;
  localparam logic [POS_W-1:0] POS_REPORT    = 5'd17;
  localparam logic [POS_W-1:0] POS_MAX       = 5'd31;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DIST_LO    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DIST_HI    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SCALE_COEF = 2'd2;

  localparam logic [REG_W-1:0] DIST_LO_RST    = 16'd0;
  localparam logic [REG_W-1:0] DIST_HI_RST    = 16'd2000;
  localparam logic [REG_W-1:0] SCALE_COEF_RST = 16'd1677;

  typedef struct packed {
    logic accept_byte;
    logic range_check;
    logic mul_dc;
    logic mul_x;
    logic mul_y;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic report_hit;
  } ctrl_stat_t;

endpackage

[rtl/core/mspffp_ctrl.sv]
// Sequencing state machine for the MSP flow frame parser.
// Depends on mspffp_pkg; drives the datapath through ctrl_cmd_t.
module mspffp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  mspffp_pkg::ctrl_stat_t stat,
  output mspffp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_MUL_DC = 6'b000100,
    ST_MUL_X  = 6'b001000,
    ST_MUL_Y  = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd             = '0;
    state_nxt       = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept_byte = in_valid;
        if (in_valid && stat.report_hit) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.range_check = 1'b1;
        state_nxt       = ST_MUL_DC;
      end
      ST_MUL_DC: begin
        cmd.mul_dc = 1'b1;
        state_nxt  = ST_MUL_X;
      end
      ST_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/mspffp_dp.sv]
// Datapath of the MSP flow frame parser: frame tracking, config
// registers, range check, shared multiplier and output register. Uses mspffp_pkg.
module mspffp_dp #(
  parameter int unsigned OUT_FRAC_BITS = mspffp_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mspffp_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [mspffp_pkg::REG_W-1:0]         cfg_data,
  input  logic [mspffp_pkg::BYTE_W-1:0]        in_rx_byte,
  input  mspffp_pkg::ctrl_cmd_t                cmd,
  output mspffp_pkg::ctrl_stat_t               stat,
  output logic signed [mspffp_pkg::OUT_W-1:0]  out_flow_x_mm,
  output logic signed [mspffp_pkg::OUT_W-1:0]  out_flow_y_mm,
  output logic [mspffp_pkg::REG_W-1:0]         out_distance_mm
);

  localparam int unsigned SHIFT  = 16 - OUT_FRAC_BITS;
  localparam int unsigned PROD_W = 2 * mspffp_pkg::WORD_W + 1;
  localparam int unsigned OUT_W  = mspffp_pkg::OUT_W;
  localparam int unsigned WORD_W = mspffp_pkg::WORD_W;
  localparam int unsigned REG_W  = mspffp_pkg::REG_W;
  localparam int unsigned POS_W  = mspffp_pkg::POS_W;
  localparam int unsigned BYTE_W = mspffp_pkg::BYTE_W;
  localparam int unsigned HEAD_W = PROD_W - OUT_W + 1;

  function automatic logic signed [OUT_W-1:0] saturate(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] s;
    logic signed [OUT_W-1:0]  r;
    s = v >>> SHIFT;
    if (s[PROD_W-1:OUT_W-1] == {HEAD_W{s[PROD_W-1]}}) begin
      r = s[OUT_W-1:0];
    end else if (s[PROD_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration
  logic [REG_W-1:0] lo_limit_r, hi_limit_r, scale_coef_r;

  // frame state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] cmd_lo_r, cmd_lo_nxt;
  logic [REG_W-1:0]  cmd_word_r, cmd_word_nxt;
  logic [WORD_W-1:0] payload_r, payload_nxt;
  logic [WORD_W-1:0] raw_x_r, raw_x_nxt;
  logic [WORD_W-1:0] raw_y_r, raw_y_nxt;
  logic [WORD_W-1:0] raw_dist_r, raw_dist_nxt;
  logic              reported_r, reported_nxt;

  // arithmetic pipeline
  logic [WORD_W-1:0]        dc_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [OUT_W-1:0]  res_x_r;
  logic signed [OUT_W-1:0]  out_x_r, out_y_r;
  logic [REG_W-1:0]         out_dist_r;

  logic [POS_W-1:0]  cur_pos;
  logic              cur_reported;
  logic              dist_fail;
  logic [WORD_W-1:0] flow_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_limit_r   <= mspffp_pkg::DIST_LO_RST;
      hi_limit_r   <= mspffp_pkg::DIST_HI_RST;
      scale_coef_r <= mspffp_pkg::SCALE_COEF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mspffp_pkg::CFG_DIST_LO:    lo_limit_r   <= cfg_data;
        mspffp_pkg::CFG_DIST_HI:    hi_limit_r   <= cfg_data;
        mspffp_pkg::CFG_SCALE_COEF: scale_coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte tracking: a sync byte restarts the frame even mid-payload
  always_comb begin
    cur_pos      = (in_rx_byte == mspffp_pkg::SYNC_BYTE) ? '0 : pos_r;
    cur_reported = (in_rx_byte == mspffp_pkg::SYNC_BYTE) ? 1'b0 : reported_r;
    cmd_lo_nxt   = cmd_lo_r;
    cmd_word_nxt = cmd_word_r;
    payload_nxt  = payload_r;
    raw_x_nxt    = raw_x_r;
    raw_y_nxt    = raw_y_r;
    raw_dist_nxt = raw_dist_r;
    if (cur_pos == mspffp_pkg::POS_CMD_LO) begin
      cmd_lo_nxt = in_rx_byte;
    end else if (cur_pos == mspffp_pkg::POS_CMD_HI) begin
      cmd_word_nxt = {in_rx_byte, cmd_lo_r};
    end else if (cur_pos >= mspffp_pkg::POS_PAY_FIRST &&
                 cur_pos <= mspffp_pkg::POS_PAY_LAST) begin
      payload_nxt = {in_rx_byte, payload_r[WORD_W-1:BYTE_W]};
      if (cur_pos == mspffp_pkg::POS_WORD0_END) begin
        if (cmd_word_r == mspffp_pkg::CMD_FLOW) begin
          raw_x_nxt = payload_nxt;
        end else if (cmd_word_r == mspffp_pkg::CMD_DISTANCE) begin
          raw_dist_nxt = payload_nxt;
        end
      end else if (cur_pos == mspffp_pkg::POS_PAY_LAST &&
                   cmd_word_r == mspffp_pkg::CMD_FLOW) begin
        raw_y_nxt = payload_nxt;
      end
    end
    pos_nxt = (cur_pos < mspffp_pkg::POS_MAX) ? cur_pos + 1'b1 : cur_pos;
    stat.report_hit = (cmd_word_nxt == mspffp_pkg::CMD_FLOW) &&
                      (pos_nxt > mspffp_pkg::POS_REPORT) && !cur_reported;
    reported_nxt = cur_reported || stat.report_hit;
  end

  // range check: negative or outside [min, max] reads as zero
  assign dist_fail = raw_dist_r[WORD_W-1] ||
                     (raw_dist_r < {{(WORD_W-REG_W){1'b0}}, lo_limit_r}) ||
                     (raw_dist_r > {{(WORD_W-REG_W){1'b0}}, hi_limit_r});

  assign flow_sel = cmd.mul_x ? raw_x_r : raw_y_r;
  assign prod_nxt = $signed({{(WORD_W+1){flow_sel[WORD_W-1]}}, flow_sel}) *
                    $signed({{(WORD_W+1){1'b0}}, dc_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      cmd_lo_r   <= '0;
      cmd_word_r <= '0;
      payload_r  <= '0;
      raw_x_r    <= '0;
      raw_y_r    <= '0;
      raw_dist_r <= '0;
      reported_r <= 1'b0;
    end else if (cmd.accept_byte) begin
      pos_r      <= pos_nxt;
      cmd_lo_r   <= cmd_lo_nxt;
      cmd_word_r <= cmd_word_nxt;
      payload_r  <= payload_nxt;
      raw_x_r    <= raw_x_nxt;
      raw_y_r    <= raw_y_nxt;
      raw_dist_r <= raw_dist_nxt;
      reported_r <= reported_nxt;
    end else if (cmd.range_check && dist_fail) begin
      raw_dist_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_dc) begin
      dc_r <= WORD_W'(raw_dist_r[REG_W-1:0]) * WORD_W'(scale_coef_r);
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mul_y) begin
      res_x_r <= saturate(prod_r);
    end
    if (cmd.load_out) begin
      out_x_r    <= res_x_r;
      out_y_r    <= saturate(prod_r);
      out_dist_r <= raw_dist_r[REG_W-1:0];
    end
  end

  assign out_flow_x_mm   = out_x_r;
  assign out_flow_y_mm   = out_y_r;
  assign out_distance_mm = out_dist_r;

endmodule

[rtl/core/msp_flow_frame_parser.sv]
// MSP flow frame parser: hooks the sequencing controller to the datapath.
// Depends on mspffp_pkg, mspffp_ctrl, mspffp_dp and the macros header.
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received
//   serial byte per transfer. A 0x24 byte restarts frame tracking anywhere.
//   Output channel (out_valid / out_stall / out_*) delivers one result per
//   flow frame (command 7938), once the byte at frame position 17 arrives.
//   Configuration (cfg_we / cfg_index / cfg_data) writes the low and high
//   distance limits and the scale coefficient; write only while the block is idle.
// Sequencing:
//   A byte that completes no report leaves in_stall low; the next byte may follow
//   in the next cycle. A reporting byte holds in_stall high through the range
//   check, distance-times-coefficient multiply, X and Y multiplies on one shared
//   33x33 multiplier and final saturation, and out_valid rises once that final
//   step loads the output register.
// Stall: the result waits in the output register while out_stall is high;
//   further bytes are still taken, and a second report holds in its final
//   step until the pending result is transferred.
// Reset: synchronous, active low; clears frame state and loads the register
//   defaults (min 0, max 2000, coefficient 1677).
`include "msp_flow_frame_parser_macros.svh"

module msp_flow_frame_parser #(
  parameter int unsigned OUT_FRAC_BITS = mspffp_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [mspffp_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [mspffp_pkg::REG_W-1:0]         cfg_data,
  // byte input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mspffp_pkg::BYTE_W-1:0]        in_rx_byte,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mspffp_pkg::OUT_W-1:0]  out_flow_x_mm,
  output logic signed [mspffp_pkg::OUT_W-1:0]  out_flow_y_mm,
  output logic [mspffp_pkg::REG_W-1:0]         out_distance_mm
);

  mspffp_pkg::ctrl_cmd_t  cmd;
  mspffp_pkg::ctrl_stat_t stat;

  // Controller: owns the handshake flags and steps the arithmetic sequence.
  mspffp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: frame tracking, config registers, multiplier, output register.
  mspffp_dp #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_rx_byte      (in_rx_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_flow_x_mm   (out_flow_x_mm),
    .out_flow_y_mm   (out_flow_y_mm),
    .out_distance_mm (out_distance_mm)
  );

  // A pending result is never overwritten by the next report.
  `MSP_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || !out_stall, "result overwritten")
  // A new result only appears after the block has been busy on a report.
  `MSP_ASSERT_NOW(a_rise_after_busy, $rose(out_valid), $past(in_stall), "result without work")
  // The distance product always follows directly on a range check.
  `MSP_ASSERT_NEXT(a_check_then_mul, cmd.range_check, cmd.mul_dc, "range check not followed")

endmodule
